>>> rtl/pog_pkg.sv
// Shared types, codes and constants of the PSR occlusion gate.
`default_nettype none

package pog_pkg;

    // Fixed field widths
    localparam int PSR_W       = 24;
    localparam int MEAN_W      = 24;
    localparam int VAR_W       = 36;
    localparam int CNT_OUT_W   = 16;
    localparam int THR_W       = 24;
    localparam int WARM_W      = 16;
    localparam int K_W         = 12;
    localparam int K_FRAC      = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Parameter defaults
    localparam int DEF_FRAC_BITS  = 12;
    localparam int DEF_COUNT_BITS = 16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OCCLUDED  = 2'd3;

    // Commands
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KSIGMA    = 2'd3;

    // Configuration reset values
    localparam logic [THR_W-1:0]  THR_RESET   = 24'd32768;
    localparam logic              SKIP_RESET  = 1'b1;
    localparam logic [WARM_W-1:0] WARM_RESET  = 16'd10;
    localparam logic [K_W-1:0]    KSIG_RESET  = 12'd768;

    typedef struct packed {
        logic [THR_W-1:0]  psr_threshold;
        logic              skip_enable;
        logic [WARM_W-1:0] warmup_count;
        logic [K_W-1:0]    k_sigma;
    } pog_cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [MEAN_W-1:0]    mean;
        logic [VAR_W-1:0]     variance;
        logic [CNT_OUT_W-1:0] count;
    } pog_result_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } pog_iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pog_iter_sts_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } pog_core_sts_t;

endpackage

`default_nettype wire

>>> rtl/pog_iter.sv
// Bit-serial shift/compare/subtract unit: restoring divide or integer square root.
`default_nettype none

module pog_iter #(
    parameter int SH_W   = 48,
    parameter int Q_W    = 37,
    parameter int REM_W  = 29,
    parameter int DVS_W  = 17,
    parameter int STEP_W = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pog_pkg::pog_iter_ctl_t ctl,
    input  logic [SH_W-1:0]        operand,
    input  logic [DVS_W-1:0]       divisor,
    input  logic [STEP_W-1:0]      steps,
    output pog_pkg::pog_iter_sts_t sts,
    output logic [Q_W-1:0]         quotient,
    output logic                   rem_nz
);
    import pog_pkg::*;

    logic [SH_W-1:0]        sh_reg;
    logic [SH_W-1:0]        sh_next;
    logic [Q_W-1:0]         q_reg;
    logic [Q_W-1:0]         q_next;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       rem_next;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic [DVS_W-1:0]       dvs_reg;
    logic                   mode_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_W-1:0]      cnt_reg;
    logic [REM_W+Q_W+1:0]   root_trial;
    logic [REM_W+DVS_W-1:0] dvs_ext;
    logic                   take;

    // Operand is left-aligned; one quotient/root bit per cycle.
    always_comb
    begin
        root_trial = {{REM_W{1'b0}}, q_reg, 2'b01};
        dvs_ext    = {{REM_W{1'b0}}, dvs_reg};
        if (mode_reg)
        begin
            rem_sh  = {rem_reg[REM_W-3:0], sh_reg[SH_W-1 -: 2]};
            trial   = root_trial[REM_W-1:0];
            sh_next = {sh_reg[SH_W-3:0], 2'b00};
        end
        else
        begin
            rem_sh  = {rem_reg[REM_W-2:0], sh_reg[SH_W-1]};
            trial   = dvs_ext[REM_W-1:0];
            sh_next = {sh_reg[SH_W-2:0], 1'b0};
        end
        take     = (rem_sh >= trial);
        rem_next = take ? (rem_sh - trial) : rem_sh;
        q_next   = {q_reg[Q_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sh_reg   <= operand;
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            mode_reg <= ctl.sqrt_mode;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = q_reg;
    assign rem_nz   = |rem_reg;

endmodule

`default_nettype wire

>>> rtl/pog_ctrl.sv
// Sequencer, running statistics and shared multiplier of the PSR occlusion gate.
`default_nettype none

module pog_ctrl #(
    parameter int FRAC_BITS  = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           command,
    input  logic [pog_pkg::PSR_W-1:0]      psr,
    input  pog_pkg::pog_cfg_t              cfg,
    input  logic                           res_take,
    output pog_pkg::pog_core_sts_t         sts,
    output pog_pkg::pog_result_t           result
);
    import pog_pkg::*;

    localparam int SQ_W   = 2 * MEAN_W - FRAC_BITS;
    localparam int E2_W   = ((SQ_W > VAR_W) ? SQ_W : VAR_W) + 1;
    localparam int RAD_W  = VAR_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int SG_W   = RAD_W / 2;
    localparam int SH_W   = (E2_W > RAD_W) ? E2_W : RAD_W;
    localparam int Q_W    = (E2_W > SG_W) ? E2_W : SG_W;
    localparam int DVS_W  = COUNT_BITS + 1;
    localparam int REM_W  = ((COUNT_BITS + 2) > (SG_W + 3)) ? (COUNT_BITS + 2) : (SG_W + 3);
    localparam int STEP_W = $clog2(SH_W + 1);
    localparam int MB_W   = (SG_W > MEAN_W) ? SG_W : MEAN_W;
    localparam int PROD_W = MEAN_W + MB_W;
    localparam int KS_W   = K_W + SG_W;
    localparam int CMP_W  = ((KS_W > (PSR_W + K_FRAC)) ? KS_W : (PSR_W + K_FRAC)) + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SQ_MEAN  = 4'd1;
    localparam logic [3:0] S_SQ_PSR   = 4'd2;
    localparam logic [3:0] S_SQ_P2    = 4'd3;
    localparam logic [3:0] S_DIV_MEAN = 4'd4;
    localparam logic [3:0] S_DIV_E2   = 4'd5;
    localparam logic [3:0] S_MSQ      = 4'd6;
    localparam logic [3:0] S_WAIT_E2  = 4'd7;
    localparam logic [3:0] S_VAR      = 4'd8;
    localparam logic [3:0] S_CHECK    = 4'd9;
    localparam logic [3:0] S_SQRT     = 4'd10;
    localparam logic [3:0] S_KSIG     = 4'd11;
    localparam logic [3:0] S_CMP      = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0]            state_reg;
    logic [MEAN_W-1:0]     mean_reg;
    logic [VAR_W-1:0]      var_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic                  ready_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [PSR_W-1:0]      psr_reg;
    logic                  up_reg;
    logic [E2_W-1:0]       e2_reg;
    logic [SQ_W-1:0]       p2_reg;
    logic [MEAN_W-1:0]     mean_new_reg;
    logic [SQ_W-1:0]       msq_reg;
    logic [E2_W-1:0]       e2n_reg;
    logic [VAR_W-1:0]      var_new_reg;
    logic [COUNT_BITS-1:0] cnt_new_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;

    logic [MEAN_W-1:0]     mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [SQ_W-1:0]       sq_hi;
    logic [SG_W-1:0]       sigma;

    pog_iter_ctl_t         iter_ctl;
    pog_iter_sts_t         iter_sts;
    logic [SH_W-1:0]       iter_operand;
    logic [STEP_W-1:0]     iter_steps;
    logic [DVS_W-1:0]      divisor;
    logic [Q_W-1:0]        iter_q;
    logic                  iter_rem_nz;

    logic                  up1;
    logic [MEAN_W-1:0]     d1;
    logic [MEAN_W+SH_W-1:0] al1;
    logic [E2_W-1:0]       p2_ext;
    logic                  up2;
    logic [E2_W-1:0]       d2;
    logic [E2_W+SH_W-1:0]  al2;
    logic [RAD_W-1:0]      rad;
    logic [RAD_W+SH_W-1:0] al3;

    logic [MEAN_W-1:0]     mean_upd;
    logic [E2_W-1:0]       e2_upd;
    logic [E2_W-1:0]       msq_ext;
    logic [E2_W-1:0]       var_diff;
    logic [E2_W-1:0]       var_wide;
    logic [VAR_W-1:0]      var_calc;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic [COUNT_BITS+CNT_OUT_W-1:0] cx_cnt;
    logic [COUNT_BITS+CNT_OUT_W-1:0] cx_warm;
    logic [COUNT_BITS+CNT_OUT_W-1:0] cx_tot;
    logic                  check_on;
    logic [CMP_W-1:0]      lhs;
    logic [CMP_W-1:0]      rhs;
    logic                  occluded;

    pog_iter #(
        .SH_W   (SH_W),
        .Q_W    (Q_W),
        .REM_W  (REM_W),
        .DVS_W  (DVS_W),
        .STEP_W (STEP_W)
    ) u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (iter_ctl),
        .operand  (iter_operand),
        .divisor  (divisor),
        .steps    (iter_steps),
        .sts      (iter_sts),
        .quotient (iter_q),
        .rem_nz   (iter_rem_nz)
    );

    assign sigma = iter_q[SG_W-1:0];
    assign sq_hi = prod_reg[2*MEAN_W-1:FRAC_BITS];

    // Shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            S_SQ_MEAN:
            begin
                mul_a = mean_reg;
                mul_b = MB_W'(mean_reg);
            end
            S_SQ_PSR:
            begin
                mul_a = psr_reg;
                mul_b = MB_W'(psr_reg);
            end
            S_DIV_E2:
            begin
                mul_a = mean_new_reg;
                mul_b = MB_W'(mean_new_reg);
            end
            S_KSIG:
            begin
                mul_a = MEAN_W'(cfg.k_sigma);
                mul_b = MB_W'(sigma);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Distances to divide and the square-root radicand, left-aligned for the serial unit
    always_comb
    begin
        up1    = (psr_reg >= mean_reg);
        d1     = up1 ? (psr_reg - mean_reg) : (mean_reg - psr_reg);
        al1    = {d1, {SH_W{1'b0}}};
        p2_ext = E2_W'(p2_reg);
        up2    = (p2_ext >= e2_reg);
        d2     = up2 ? (p2_ext - e2_reg) : (e2_reg - p2_ext);
        al2    = {d2, {SH_W{1'b0}}};
        rad    = RAD_W'({var_new_reg, {FRAC_BITS{1'b0}}});
        al3    = {rad, {SH_W{1'b0}}};
    end

    assign divisor = DVS_W'(total_reg) + DVS_W'(1);

    always_comb
    begin
        cx_cnt   = {{CNT_OUT_W{1'b0}}, cnt_new_reg};
        cx_warm  = {{COUNT_BITS{1'b0}}, cfg.warmup_count};
        check_on = cfg.skip_enable && (cx_cnt >= cx_warm);
    end

    always_comb
    begin
        iter_ctl.start     = 1'b0;
        iter_ctl.sqrt_mode = 1'b0;
        iter_operand       = al1[MEAN_W+SH_W-1 -: SH_W];
        iter_steps         = STEP_W'(MEAN_W);
        unique case (state_reg)
            S_SQ_MEAN:
            begin
                iter_ctl.start = 1'b1;
            end
            S_DIV_E2:
            begin
                iter_ctl.start = 1'b1;
                iter_operand   = al2[E2_W+SH_W-1 -: SH_W];
                iter_steps     = STEP_W'(E2_W);
            end
            S_CHECK:
            begin
                iter_ctl.start     = check_on;
                iter_ctl.sqrt_mode = 1'b1;
                iter_operand       = al3[RAD_W+SH_W-1 -: SH_W];
                iter_steps         = STEP_W'(SG_W);
            end
            default:
            begin
                iter_ctl.start = 1'b0;
            end
        endcase
    end

    // Step toward the new sample: floor on the way up, ceiling on the way down
    always_comb
    begin
        mean_upd = up_reg ? (mean_reg + iter_q[MEAN_W-1:0])
                          : (mean_reg - iter_q[MEAN_W-1:0] - MEAN_W'(iter_rem_nz));
        e2_upd   = up_reg ? (e2_reg + iter_q[E2_W-1:0])
                          : (e2_reg - iter_q[E2_W-1:0] - E2_W'(iter_rem_nz));
    end

    always_comb
    begin
        msq_ext  = E2_W'(msq_reg);
        var_diff = e2n_reg - msq_ext;
        var_wide = (e2n_reg > msq_ext) ? var_diff : '0;
        var_calc = (|var_wide[E2_W-1:VAR_W]) ? '1 : var_wide[VAR_W-1:0];
        cnt_sat  = (&total_reg) ? total_reg : (total_reg + COUNT_BITS'(1));
    end

    always_comb
    begin
        lhs      = CMP_W'({psr_reg, {K_FRAC{1'b0}}}) + CMP_W'(prod_reg[KS_W-1:0]);
        rhs      = CMP_W'({mean_new_reg, {K_FRAC{1'b0}}});
        occluded = (lhs <= rhs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mean_reg   <= '0;
            var_reg    <= '0;
            total_reg  <= '0;
            ready_reg  <= 1'b0;
            status_reg <= ST_ACCEPTED;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (command == CMD_CLEAR)
                        begin
                            mean_reg   <= '0;
                            var_reg    <= '0;
                            total_reg  <= '0;
                            ready_reg  <= 1'b1;
                            status_reg <= ST_ACCEPTED;
                            state_reg  <= S_OUT;
                        end
                        else if (!ready_reg)
                        begin
                            status_reg <= ST_NOT_READY;
                            state_reg  <= S_OUT;
                        end
                        else if (psr < cfg.psr_threshold)
                        begin
                            status_reg <= ST_BELOW;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_SQ_MEAN;
                        end
                    end
                end
                S_SQ_MEAN:  state_reg <= S_SQ_PSR;
                S_SQ_PSR:   state_reg <= S_SQ_P2;
                S_SQ_P2:    state_reg <= S_DIV_MEAN;
                S_DIV_MEAN:
                begin
                    if (iter_sts.done)
                    begin
                        state_reg <= S_DIV_E2;
                    end
                end
                S_DIV_E2:   state_reg <= S_MSQ;
                S_MSQ:      state_reg <= S_WAIT_E2;
                S_WAIT_E2:
                begin
                    if (iter_sts.done)
                    begin
                        state_reg <= S_VAR;
                    end
                end
                S_VAR:      state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (check_on)
                    begin
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        mean_reg   <= mean_new_reg;
                        var_reg    <= var_new_reg;
                        total_reg  <= cnt_new_reg;
                        status_reg <= ST_ACCEPTED;
                        state_reg  <= S_OUT;
                    end
                end
                S_SQRT:
                begin
                    if (iter_sts.done)
                    begin
                        state_reg <= S_KSIG;
                    end
                end
                S_KSIG:     state_reg <= S_CMP;
                S_CMP:
                begin
                    // occlusion leaves the statistics as they were
                    if (occluded)
                    begin
                        status_reg <= ST_OCCLUDED;
                    end
                    else
                    begin
                        mean_reg   <= mean_new_reg;
                        var_reg    <= var_new_reg;
                        total_reg  <= cnt_new_reg;
                        status_reg <= ST_ACCEPTED;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (state_reg == S_IDLE && start)
        begin
            psr_reg <= psr;
        end
        if (state_reg == S_SQ_MEAN)
        begin
            up_reg <= up1;
        end
        if (state_reg == S_DIV_E2)
        begin
            up_reg <= up2;
        end
        if (state_reg == S_SQ_PSR)
        begin
            e2_reg <= E2_W'(var_reg) + E2_W'(sq_hi);
        end
        if (state_reg == S_SQ_P2)
        begin
            p2_reg <= sq_hi;
        end
        if (state_reg == S_DIV_MEAN && iter_sts.done)
        begin
            mean_new_reg <= mean_upd;
        end
        if (state_reg == S_MSQ)
        begin
            msq_reg <= sq_hi;
        end
        if (state_reg == S_WAIT_E2 && iter_sts.done)
        begin
            e2n_reg <= e2_upd;
        end
        if (state_reg == S_VAR)
        begin
            var_new_reg <= var_calc;
            cnt_new_reg <= cnt_sat;
        end
    end

    assign cx_tot = {{CNT_OUT_W{1'b0}}, total_reg};

    assign sts.idle        = (state_reg == S_IDLE);
    assign sts.res_valid   = (state_reg == S_OUT);
    assign result.status   = status_reg;
    assign result.mean     = mean_reg;
    assign result.variance = var_reg;
    assign result.count    = cx_tot[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/psr_occlusion_gate_core.sv
// Top level of the PSR occlusion gate: configuration registers, handshakes, result register.
`default_nettype none

// One PSR value per item. A clear command, or a value rejected as not ready or below
// threshold, goes from idle directly to the output state. An evaluated value goes through
// the bit-serial divide/root unit: MEAN_W + E2_W steps of division (24 + 37 at
// FRAC_BITS = 12) and, when the occlusion check applies, (36 + FRAC_BITS) / 2, rounded
// up, square root steps (24), plus sequencing and multiplies. Items are taken one at a
// time, and a finished result waits in the output register while the next item is
// already accepted.
module psr_occlusion_gate_core #(
    parameter int FRAC_BITS  = pog_pkg::DEF_FRAC_BITS,
    parameter int COUNT_BITS = pog_pkg::DEF_COUNT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic                               command,
    input  logic [pog_pkg::PSR_W-1:0]          psr,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [pog_pkg::STATUS_W-1:0]       status,
    output logic [pog_pkg::MEAN_W-1:0]         mean_out,
    output logic [pog_pkg::VAR_W-1:0]          variance_out,
    output logic [pog_pkg::CNT_OUT_W-1:0]      count_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pog_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pog_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pog_pkg::*;

    pog_cfg_t      cfg_reg;
    pog_core_sts_t core_sts;
    pog_result_t   core_res;
    pog_result_t   rsp_reg;
    logic          rsp_valid_reg;
    logic          res_take;
    logic          start;

    assign cfg_ready = 1'b1;
    assign req_ready = core_sts.idle;
    assign start     = req_valid && req_ready;
    assign res_take  = core_sts.res_valid && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.psr_threshold <= THR_RESET;
            cfg_reg.skip_enable   <= SKIP_RESET;
            cfg_reg.warmup_count  <= WARM_RESET;
            cfg_reg.k_sigma       <= KSIG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.psr_threshold <= cfg_data[THR_W-1:0];
                CFG_SKIP:      cfg_reg.skip_enable   <= cfg_data[0];
                CFG_WARMUP:    cfg_reg.warmup_count  <= cfg_data[WARM_W-1:0];
                CFG_KSIGMA:    cfg_reg.k_sigma       <= cfg_data[K_W-1:0];
            endcase
        end
    end

    pog_ctrl #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .psr      (psr),
        .cfg      (cfg_reg),
        .res_take (res_take),
        .sts      (core_sts),
        .result   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= core_res;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_reg.status;
    assign mean_out     = rsp_reg.mean;
    assign variance_out = rsp_reg.variance;
    assign count_out    = rsp_reg.count;

endmodule

`default_nettype wire

>>> rtl/pog_checker.sv
// Port-level assertions for the PSR occlusion gate, bound to the top level.
`default_nettype none

module pog_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic [pog_pkg::STATUS_W-1:0]       status,
    input  logic [pog_pkg::MEAN_W-1:0]         mean_out,
    input  logic [pog_pkg::VAR_W-1:0]          variance_out,
    input  logic [pog_pkg::CNT_OUT_W-1:0]      count_out
);
    import pog_pkg::*;

    // one item at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("gate ready again right after accepting an item");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(mean_out)
            && $stable(variance_out) && $stable(count_out))
        else $error("stalled result changed or dropped");

    // before the first clear the statistics are still at reset
    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_NOT_READY |->
            mean_out == '0 && variance_out == '0 && count_out == '0)
        else $error("not-ready result with non-zero statistics");

    // a new result is only offered while the input side is held off
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared while the gate was idle");

endmodule

bind psr_occlusion_gate_core pog_checker u_pog_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .mean_out     (mean_out),
    .variance_out (variance_out),
    .count_out    (count_out)
);

`default_nettype wire

>>> tb/psr_occlusion_gate_core_test.sv
// Self-checking testbench for the PSR occlusion gate core: directed cases, then random phases.
`timescale 1ns / 1ps

module psr_occlusion_gate_core_test;
    import pog_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int PSR_TOP = (1 << PSR_W) - 1;
    localparam longint unsigned VAR_TOP = (64'd1 << VAR_W) - 1;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  req_valid    = 1'b0;
    logic                  req_ready;
    logic                  command      = CMD_CLEAR;
    logic [PSR_W-1:0]      psr          = '0;
    logic                  rsp_valid;
    logic                  rsp_ready    = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [MEAN_W-1:0]     mean_out;
    logic [VAR_W-1:0]      variance_out;
    logic [CNT_OUT_W-1:0]  count_out;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Gate model: statistics and register shadow
    pog_cfg_t              gate_cfg;
    logic [MEAN_W-1:0]     st_mean;
    logic [VAR_W-1:0]      st_var;
    logic [CNT_OUT_W-1:0]  st_count;
    logic                  st_ready;

    pog_result_t           due_results[$];
    pog_result_t           want;
    pog_result_t           got;

    int  mismatches = 0;
    int  items_sent = 0;
    int  clears_sent = 0;
    int  reg_writes = 0;
    int  settings_used = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;
    bit  hold_for_drain = 1'b0;

    psr_occlusion_gate_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .command      (command),
        .psr          (psr),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .mean_out     (mean_out),
        .variance_out (variance_out),
        .count_out    (count_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor(base + (x - base) / m), rounding towards minus infinity on both sides
    function automatic longint unsigned step_toward(input longint unsigned base,
                                                    input longint unsigned x,
                                                    input longint unsigned m);
        if (x >= base)
            return base + (x - base) / m;
        return base - ((base - x) + m - 64'd1) / m;
    endfunction

    function automatic longint unsigned sq_frac(input longint unsigned x);
        return (x * x) >> FRAC;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic pog_result_t gate_step(input logic cmd,
                                              input logic [PSR_W-1:0] value);
        pog_result_t     r;
        longint unsigned pv;
        longint unsigned m;
        longint unsigned mean_nx;
        longint unsigned e2_nx;
        longint unsigned msq;
        longint unsigned var_nx;
        longint unsigned sigma;
        longint unsigned kv;
        logic [CNT_OUT_W-1:0] cnt_nx;
        r.status = ST_ACCEPTED;
        if (cmd == CMD_CLEAR)
        begin
            st_mean  = '0;
            st_var   = '0;
            st_count = '0;
            st_ready = 1'b1;
        end
        else if (!st_ready)
            r.status = ST_NOT_READY;
        else if (value < gate_cfg.psr_threshold)
            r.status = ST_BELOW;
        else
        begin
            pv = 64'(value);
            m = 64'(st_count) + 64'd1;
            mean_nx = step_toward(64'(st_mean), pv, m) & 64'hFF_FFFF;
            e2_nx = step_toward(64'(st_var) + sq_frac(64'(st_mean)), sq_frac(pv), m);
            msq = sq_frac(mean_nx);
            var_nx = (e2_nx > msq) ? e2_nx - msq : 64'd0;
            if (var_nx > VAR_TOP)
                var_nx = VAR_TOP;
            cnt_nx = (st_count != '1) ? st_count + CNT_OUT_W'(1) : st_count;
            if (gate_cfg.skip_enable && cnt_nx >= gate_cfg.warmup_count)
            begin
                sigma = floor_root(var_nx << FRAC);
                kv = 64'(gate_cfg.k_sigma);
                if ((pv << K_FRAC) + kv * sigma <= (mean_nx << K_FRAC))
                    r.status = ST_OCCLUDED;
            end
            if (r.status != ST_OCCLUDED)
            begin
                st_mean  = mean_nx[MEAN_W-1:0];
                st_var   = var_nx[VAR_W-1:0];
                st_count = cnt_nx;
            end
        end
        r.mean     = st_mean;
        r.variance = st_var;
        r.count    = st_count;
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long one
    function automatic int idle_len(input bit calm);
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PSR_W-1:0] clip_psr(input int v, input int lo);
        if (v < lo)
            v = lo;
        if (v > PSR_TOP)
            v = PSR_TOP;
        return PSR_W'(v);
    endfunction

    task automatic wait_drained();
        do @(posedge clk); while (due_results.size() != 0);
    endtask

    task automatic send_item(input logic cmd, input logic [PSR_W-1:0] value);
        int gap;
        gap = idle_len(src_calm);
        if (hold_for_drain || gap > 0)
        begin
            req_valid <= 1'b0;
            if (hold_for_drain)
                wait_drained();
            hold_for_drain = 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        psr       <= value;
        do @(posedge clk); while (!req_ready);
        due_results.push_back(gate_step(cmd, value));
        items_sent++;
        if (cmd == CMD_CLEAR)
            clears_sent++;
    endtask

    task automatic finish_burst();
        req_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: gate_cfg.psr_threshold = data[THR_W-1:0];
            CFG_SKIP:      gate_cfg.skip_enable   = data[0];
            CFG_WARMUP:    gate_cfg.warmup_count  = data[WARM_W-1:0];
            CFG_KSIGMA:    gate_cfg.k_sigma       = data[K_W-1:0];
            default:       ;
        endcase
        reg_writes++;
    endtask

    // Only called with nothing in flight
    task automatic set_gate_config(input logic [THR_W-1:0] thr, input logic skip,
                                   input logic [WARM_W-1:0] warm, input logic [K_W-1:0] k);
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_SKIP, CFG_DATA_W'(skip));
        write_reg(CFG_WARMUP, CFG_DATA_W'(warm));
        write_reg(CFG_KSIGMA, CFG_DATA_W'(k));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_before_clear();
        send_item(CMD_EVAL, '1);
        send_item(CMD_EVAL, '0);
        finish_burst();
    endtask

    // Reset register values: threshold 8.0, warmup 10
    task automatic test_threshold_edges();
        send_item(CMD_CLEAR, 24'h5A5A5A);
        send_item(CMD_EVAL, THR_RESET - 1'b1);
        send_item(CMD_EVAL, THR_RESET);
        send_item(CMD_EVAL, '1);
        finish_burst();
    endtask

    // Tight cluster round 15.0, then a dip well under one sigma; check on from the 4th sample
    task automatic test_occlusion_window();
        set_gate_config(THR_RESET, 1'b1, 16'd4, 12'd256);
        send_item(CMD_CLEAR, '0);
        send_item(CMD_EVAL, 24'd61440);
        send_item(CMD_EVAL, 24'd61952);
        send_item(CMD_EVAL, 24'd60928);
        send_item(CMD_EVAL, 24'd40960);
        send_item(CMD_EVAL, 24'd61440);
        finish_burst();
        set_gate_config(THR_RESET, 1'b0, 16'd4, 12'd256);
        send_item(CMD_EVAL, 24'd40960);
        finish_burst();
    endtask

    // No warmup: first sample has zero variance and sits on the mean
    task automatic test_zero_warmup();
        set_gate_config('0, 1'b1, '0, '0);
        send_item(CMD_CLEAR, '1);
        send_item(CMD_EVAL, '0);
        send_item(CMD_EVAL, '1);
        finish_burst();
    endtask

    task automatic test_wide_sigma();
        set_gate_config('0, 1'b1, 16'd2, '1);
        send_item(CMD_CLEAR, 24'hA5A5A5);
        send_item(CMD_EVAL, 24'd4096);
        send_item(CMD_EVAL, '1);
        send_item(CMD_EVAL, 24'd4096);
        finish_burst();
    endtask

    // Per phase: new registers, then runs of clear + clustered values with dips and noise, or short random bursts
    task automatic test_random_phases();
        int thr;
        int warm;
        int k;
        bit skip;
        int phase;
        int budget;
        int phase_items;
        int seq_no;
        int burst;
        int span;
        int base;
        int amp;
        int len;
        int pick;
        logic [PSR_W-1:0] value;
        phase = 0;
        while (items_sent < 1900)
        begin
            if (phase == 0)
            begin
                thr  = PSR_TOP;
                skip = 1'b1;
                warm = 65535;
                k    = KSIG_RESET;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       thr = 0;
                    1:       thr = PSR_TOP;
                    2:       thr = $urandom_range(0, PSR_TOP);
                    default: thr = $urandom_range(0, 65536);
                endcase
                case ($urandom_range(0, 9))
                    0:       warm = 0;
                    1:       warm = 1;
                    2:       warm = 65535;
                    3:       warm = $urandom_range(0, 65535);
                    default: warm = $urandom_range(2, 24);
                endcase
                case ($urandom_range(0, 9))
                    0:       k = 0;
                    1:       k = 4095;
                    2:       k = $urandom_range(0, 4095);
                    default: k = $urandom_range(128, 1024);
                endcase
                skip = ($urandom_range(0, 4) != 0);
            end
            set_gate_config(THR_W'(thr), skip, WARM_W'(warm), K_W'(k));
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            budget = $urandom_range(100, 250);
            phase_items = 0;
            seq_no = 0;
            while (phase_items < budget && items_sent < 1900)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    burst = $urandom_range(1, 6);
                    repeat (burst)
                    begin
                        send_item(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_EVAL,
                                  PSR_W'($urandom));
                        phase_items++;
                    end
                end
                else
                begin
                    hold_for_drain = (seq_no % 8 == 3);
                    span = 1 << $urandom_range(4, 22);
                    base = int'(clip_psr(thr + int'($urandom_range(0, span)), thr));
                    amp  = (base >> $urandom_range(2, 8)) + 1;
                    len  = $urandom_range(4, 40);
                    send_item(CMD_CLEAR, PSR_W'($urandom));
                    repeat (len)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 8)
                            value = clip_psr(base - amp * int'($urandom_range(2, 6)), thr);
                        else if (pick < 12)
                            value = (thr > 0) ? PSR_W'($urandom_range(0, thr - 1))
                                              : PSR_W'($urandom);
                        else if (pick < 15)
                            value = PSR_W'($urandom);
                        else
                            value = clip_psr(base + int'($urandom_range(0, 2 * amp)) - amp, 0);
                        send_item(CMD_EVAL, value);
                    end
                    phase_items += len + 1;
                    seq_no++;
                end
            end
            finish_burst();
            phase++;
        end
    endtask

    // Result side back-pressure
    initial
    begin : sink_stalls
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (sink_calm)
                rsp_ready <= 1'b1;
            else if ($urandom_range(0, 2) != 0)
            begin
                rsp_ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
            else
            begin
                rsp_ready <= 1'b0;
                hold = idle_len(1'b0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got = {status, mean_out, variance_out, count_out};
            if (due_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result: status %0d mean %0h var %0h count %0d",
                             $realtime, got.status, got.mean, got.variance, got.count);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                status_seen[want.status]++;
                if (got.status !== want.status || got.mean !== want.mean ||
                    got.variance !== want.variance || got.count !== want.count)
                begin
                    if (mismatches < 10)
                        $display("%0t: exp/act st %0d/%0d mean %0h/%0h var %0h/%0h cnt %0d/%0d",
                                 $realtime, want.status, got.status, want.mean, got.mean,
                                 want.variance, got.variance, want.count, got.count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        gate_cfg.psr_threshold = THR_RESET;
        gate_cfg.skip_enable   = SKIP_RESET;
        gate_cfg.warmup_count  = WARM_RESET;
        gate_cfg.k_sigma       = KSIG_RESET;
        st_mean  = '0;
        st_var   = '0;
        st_count = '0;
        st_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_before_clear();
        test_threshold_edges();
        test_occlusion_window();
        test_zero_warmup();
        test_wide_sigma();
        test_random_phases();

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Sent %0d items (%0d clears) across %0d register settings, %0d register writes.",
                 items_sent, clears_sent, settings_used, reg_writes);
        $display("Results: %0d accepted, %0d not ready, %0d below threshold, %0d occlusion skips.",
                 status_seen[ST_ACCEPTED], status_seen[ST_NOT_READY], status_seen[ST_BELOW],
                 status_seen[ST_OCCLUDED]);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("Timeout with %0d results outstanding", due_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
